[design/lca_pkg.sv]
// Shared types and constants for the Game of Life core.
`timescale 1ns / 1ps
`default_nettype none

package lca_pkg;

    localparam int DEF_ROWS = 32;
    localparam int DEF_COLS = 64;

    localparam int CMD_W = 2;
    localparam int ROW_W = 5;
    localparam int COL_W = 6;

    // Neighbor counts of the B3/S23 rule.
    localparam int SURVIVE_CNT = 2;
    localparam int BIRTH_CNT   = 3;

    localparam logic [CMD_W-1:0] CMD_TOGGLE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_STEP   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_req;

    typedef struct packed {
        logic cell_state;
        logic any_alive;
        logic rejected;
    } t_rsp;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RMW,
        ST_SWEEP,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

[design/life_cellular_automaton_core.sv]
// Game of Life core: ROWS x COLS grid in a row memory with toggle, read and step commands.
//
// Requests enter on i_in_valid / o_in_ready with payload i_req (cmd, row, col).
// Each request yields exactly one response on o_out_valid / i_out_ready with
// payload o_rsp (cell_state, any_alive, rejected).
// The grid is held one row per memory word; the memory has a registered read.
// Toggle and read: the row is read in the accept cycle; an interior toggle
// modifies it and writes it back while the response is loaded, which waits
// until the output register is free. Other toggles are rejected.
// A step sweeps the memory one row per cycle, keeping a window of three rows
// and writing each new row behind the read pointer; its response is loaded
// once the last row is written and the output register is free.
// A new request is accepted once the previous one has loaded its response,
// so the next request can be accepted while that response is still waiting.
// If the receiver stalls, the block holds its result until the output
// register is free and accepts nothing meanwhile.
// Reset clears the per-row valid flags and the live-row count, so the whole
// grid reads as dead immediately; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module life_cellular_automaton_core #(
    parameter int ROWS = lca_pkg::DEF_ROWS,
    parameter int COLS = lca_pkg::DEF_COLS
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire lca_pkg::t_req i_req,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output lca_pkg::t_rsp      o_rsp
);
    import lca_pkg::*;

    localparam int RW = $clog2(ROWS);
    localparam int CW = $clog2(ROWS + 1);

    // Row memory and one valid flag per row.
    logic [COLS-1:0] r_mem [ROWS];
    logic [ROWS-1:0] r_vld;

    t_state          r_state, n_state;
    t_req            r_req;
    logic            r_in_range;
    logic [RW-1:0]   r_ptr, n_ptr;
    logic            r_issue, n_issue;
    logic            r_rd_vld;
    logic [RW-1:0]   r_rd_row;
    logic [COLS-1:0] r_rd_data;
    logic            r_rd_ok;
    logic [COLS-1:0] r_above, r_mid;
    logic [CW-1:0]   r_acc, n_acc;
    logic [CW-1:0]   r_alive_cnt, n_alive_cnt;
    logic            r_out_vld;
    t_rsp            r_rsp, n_rsp;

    logic            rd_en;
    logic [RW-1:0]   rd_addr;
    logic            wr_en;
    logic [RW-1:0]   wr_addr;
    logic [COLS-1:0] wr_data;
    logic            out_load;
    logic            out_free;
    logic            accept;
    logic            req_in_range;
    logic [COLS-1:0] rd_row_data;
    logic [COLS-1:0] col_hot;
    logic [COLS-1:0] toggled;
    logic [COLS-1:0] step_row;
    logic            interior;

    assign accept       = i_in_valid && o_in_ready;
    assign o_in_ready   = (r_state == ST_IDLE);
    assign out_free     = !r_out_vld || i_out_ready;
    assign req_in_range = int'(i_req.row) < ROWS;
    assign rd_row_data  = r_rd_ok ? r_rd_data : '0;
    assign toggled      = rd_row_data ^ col_hot;
    assign interior     = (int'(r_req.row) >= 1) && (int'(r_req.row) < ROWS - 1)
                       && (int'(r_req.col) >= 1) && (int'(r_req.col) < COLS - 1);

    always_comb begin
        for (int c = 0; c < COLS; c++) begin
            col_hot[c] = (int'(r_req.col) == c);
        end
    end

    lca_row_rule #(
        .COLS (COLS)
    ) u_rule (
        .i_above (r_above),
        .i_mid   (r_mid),
        .i_below (rd_row_data),
        .o_next  (step_row)
    );

    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_issue     = r_issue;
        n_acc       = r_acc;
        n_alive_cnt = r_alive_cnt;
        n_rsp       = '0;
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = '0;
        out_load    = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_req.cmd == CMD_STEP) begin
                        rd_en   = 1'b1;
                        rd_addr = '0;
                        n_ptr   = RW'(1);
                        n_issue = 1'b1;
                        n_acc   = '0;
                        n_state = ST_SWEEP;
                    end else begin
                        rd_en   = req_in_range;
                        rd_addr = RW'(i_req.row);
                        n_state = ST_RMW;
                    end
                end
            end

            ST_RMW: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                    if (r_req.cmd == CMD_TOGGLE) begin
                        if (interior) begin
                            wr_en       = 1'b1;
                            wr_addr     = RW'(r_req.row);
                            wr_data     = toggled;
                            n_alive_cnt = r_alive_cnt + CW'(|toggled) - CW'(|rd_row_data);
                            n_rsp.cell_state = |(toggled & col_hot);
                        end else begin
                            n_rsp.rejected = 1'b1;
                        end
                    end else if (r_req.cmd == CMD_READ) begin
                        n_rsp.cell_state = r_in_range && |(rd_row_data & col_hot);
                    end
                    n_rsp.any_alive = (n_alive_cnt != '0);
                end
            end

            ST_SWEEP: begin
                if (r_issue) begin
                    rd_en   = 1'b1;
                    rd_addr = r_ptr;
                    n_ptr   = RW'(r_ptr + 1'b1);
                    if (r_ptr == RW'(ROWS - 1)) begin
                        n_issue = 1'b0;
                    end
                end
                // Row k arriving, for k of 2 or more, completes the window for row k-1.
                if (r_rd_vld && (r_rd_row >= RW'(2))) begin
                    wr_en   = 1'b1;
                    wr_addr = RW'(r_rd_row - 1'b1);
                    wr_data = step_row;
                    n_acc   = r_acc + CW'(|step_row);
                    if (r_rd_row == RW'(ROWS - 1)) begin
                        n_alive_cnt = n_acc;
                        n_state     = ST_DONE;
                    end
                end
            end

            ST_DONE: begin
                if (out_free) begin
                    out_load        = 1'b1;
                    n_rsp.any_alive = (r_alive_cnt != '0);
                    n_state         = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_vld       <= '0;
            r_issue     <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_alive_cnt <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_issue     <= n_issue;
            r_rd_vld    <= rd_en;
            r_alive_cnt <= n_alive_cnt;
            if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        r_acc <= n_acc;
        if (accept) begin
            r_req      <= i_req;
            r_in_range <= req_in_range;
        end
        if (rd_en) begin
            r_rd_row <= rd_addr;
            r_rd_ok  <= r_vld[rd_addr];
        end
        if (r_state == ST_SWEEP && r_rd_vld) begin
            r_above <= r_mid;
            r_mid   <= rd_row_data;
        end
        if (out_load) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_rsp       = r_rsp;

    // The border rows are never written, so they always read as dead.
    a_no_border_row_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (wr_addr != '0) && (wr_addr != RW'(ROWS - 1)))
        else $error("write to a border row");

    a_no_border_col_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> !wr_data[0] && !wr_data[COLS-1])
        else $error("border column set in a written row");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_alive_cnt) <= ROWS)
        else $error("live-row count exceeds the row count");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != ST_IDLE))
        else $error("request accepted without starting work");

    a_load_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> out_free)
        else $error("response loaded over an untaken response");

endmodule

`default_nettype wire

[design/lca_row_rule.sv]
// Next-generation row from three adjacent rows under rule B3/S23.
`timescale 1ns / 1ps
`default_nettype none

module lca_row_rule #(
    parameter int COLS = lca_pkg::DEF_COLS
) (
    input  wire logic [COLS-1:0] i_above,
    input  wire logic [COLS-1:0] i_mid,
    input  wire logic [COLS-1:0] i_below,
    output logic [COLS-1:0]      o_next
);
    import lca_pkg::*;

    assign o_next[0]      = 1'b0;
    assign o_next[COLS-1] = 1'b0;

    // One independent lane per interior column; border columns stay dead.
    for (genvar c = 1; c < COLS - 1; c++) begin : g_lane
        logic [3:0] w_cnt;

        assign w_cnt = 4'(i_above[c-1]) + 4'(i_above[c]) + 4'(i_above[c+1])
                     + 4'(i_mid[c-1])                    + 4'(i_mid[c+1])
                     + 4'(i_below[c-1]) + 4'(i_below[c]) + 4'(i_below[c+1]);

        assign o_next[c] = (w_cnt == 4'(BIRTH_CNT))
                         || (i_mid[c] && (w_cnt == 4'(SURVIVE_CNT)));
    end

endmodule

`default_nettype wire
